// File: design/psr_pkg.sv
`timescale 1ns / 1ps

package psr_pkg;

    localparam int PADDR_W = 5;

    localparam logic [1:0] SHAPE_DISC = 2'd0;
    localparam logic [1:0] SHAPE_STAR = 2'd1;
    localparam logic [1:0] SHAPE_BLOB = 2'd2;

    typedef enum logic [2:0] {
        REG_SHAPE   = 3'd0,
        REG_RED     = 3'd1,
        REG_GREEN   = 3'd2,
        REG_BLUE    = 3'd3,
        REG_OPACITY = 3'd4
    } psr_reg_t;

    typedef struct packed {
        logic [1:0] shape;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] opacity;
    } psr_cfg_t;

    localparam psr_cfg_t CFG_RESET = '{
        shape:   SHAPE_DISC,
        red:     8'd255,
        green:   8'd255,
        blue:    8'd255,
        opacity: 8'd70
    };

    typedef struct packed {
        logic       valid;
        logic       hit;
        logic [7:0] alpha;
    } psr_cov_t;

    localparam logic [4:0] DISC_SIZE   = 5'd10;
    localparam logic [4:0] SPRITE_SIZE = 5'd30;
    localparam logic [13:0] DISC_RAD_SQ = 14'd100;

    // floor(x / 100) = (x * 5243) >> 19 for x below 25600.
    localparam logic [12:0] RECIP_100 = 13'd5243;
    localparam int          SHIFT_100 = 19;
    // floor(x / 255) = (x * 32897) >> 23 for x up to 255 * 255.
    localparam logic [15:0] RECIP_255 = 16'd32897;
    localparam int          SHIFT_255 = 23;

    localparam int NUM_VERTS = 10;
    localparam int NUM_BLOBS = 4;

    // Star outline in 1/256 pixel.
    localparam logic signed [14:0] STAR_X [NUM_VERTS] = '{
        15'sd3840, 15'sd4655, 15'sd7309, 15'sd5158, 15'sd5984,
        15'sd3840, 15'sd1696, 15'sd2522, 15'sd371,  15'sd3025
    };
    localparam logic signed [14:0] STAR_Y [NUM_VERTS] = '{
        15'sd192,  15'sd2719, 15'sd2713, 15'sd4268, 15'sd6791,
        15'sd5226, 15'sd6791, 15'sd4268, 15'sd2713, 15'sd2719
    };

    // Ellipses in units of 1/100 of the sprite: centers times three, radii.
    localparam int BLOB_CX3 [NUM_BLOBS] = '{150, 150, 150, 165};
    localparam int BLOB_CY3 [NUM_BLOBS] = '{246, 180, 120, 69};
    localparam int BLOB_RX  [NUM_BLOBS] = '{42, 33, 23, 12};
    localparam int BLOB_RY  [NUM_BLOBS] = '{18, 20, 18, 12};

endpackage

// File: design/procedural_sprite_rasterizer.sv
`timescale 1ns / 1ps

// Sprite pixel generator. Each input beat carries a pixel column and row;
// each output beat carries the premultiplied ARGB value of that pixel and
// a flag that tells whether the pixel is covered by the selected shape.
// The shape, color and peak alpha come from registers on the APB port. The
// user must change them only while no beat is in flight; the block does not enforce it.
// The datapath is five register stages deep. While the output is not stalled,
// a new beat is taken every cycle, so the block sustains one pixel per clock;
// the stages are the vertex and center offsets, the edge and ellipse
// products, the inside tests with the disc falloff, the color products and
// the divide by 255.
// When the receiver stalls a valid output, the whole pipeline holds and
// pix_stall goes high in the same cycle; nothing is dropped or repeated.
// Reset empties the pipeline and loads the default registers: disc shape,
// white color, peak alpha 70.

module procedural_sprite_rasterizer
    import psr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pix_valid,
    output logic               pix_stall,
    input  logic [4:0]         pix_col,
    input  logic [4:0]         pix_row,
    output logic               res_valid,
    input  logic               res_stall,
    output logic [31:0]        argb_pixel,
    output logic               covered,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    psr_cfg_t cfg;
    psr_cov_t cov;
    logic     en;

    assign en        = !(res_valid && res_stall);
    assign pix_stall = !en;

    psr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    psr_cover u_cover (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (pix_valid),
        .col      (pix_col),
        .row      (pix_row),
        .cfg      (cfg),
        .cov      (cov)
    );

    psr_shade u_shade (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .cov        (cov),
        .cfg        (cfg),
        .res_valid  (res_valid),
        .argb_pixel (argb_pixel),
        .covered    (covered)
    );

endmodule

// File: design/psr_regs.sv
`timescale 1ns / 1ps

module psr_regs
    import psr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output psr_cfg_t           cfg
);

    psr_cfg_t cfg_reg;
    psr_cfg_t cfg_next;
    psr_reg_t idx;
    logic     wr;

    assign idx    = psr_reg_t'(paddr[PADDR_W-1:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            unique case (idx)
                REG_SHAPE:   cfg_next.shape   = pwdata[1:0];
                REG_RED:     cfg_next.red     = pwdata[7:0];
                REG_GREEN:   cfg_next.green   = pwdata[7:0];
                REG_BLUE:    cfg_next.blue    = pwdata[7:0];
                REG_OPACITY: cfg_next.opacity = pwdata[7:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_SHAPE:   prdata = {30'd0, cfg_reg.shape};
            REG_RED:     prdata = {24'd0, cfg_reg.red};
            REG_GREEN:   prdata = {24'd0, cfg_reg.green};
            REG_BLUE:    prdata = {24'd0, cfg_reg.blue};
            REG_OPACITY: prdata = {24'd0, cfg_reg.opacity};
            default:     prdata = 32'd0;
        endcase
    end

endmodule

// File: design/psr_cover.sv
`timescale 1ns / 1ps

module psr_cover
    import psr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic       in_valid,
    input  logic [4:0] col,
    input  logic [4:0] row,
    input  psr_cfg_t   cfg,
    output psr_cov_t   cov
);

    // Stage 1: offsets from vertices and centers, disc distance.
    logic signed [14:0] px;
    logic signed [14:0] py;
    logic signed [9:0]  cpos;
    logic signed [9:0]  rpos;
    logic signed [6:0]  dxd;
    logic signed [6:0]  dyd;
    logic signed [13:0] sqx;
    logic signed [13:0] sqy;
    logic [13:0]        dsq;
    logic [13:0]        rem;

    logic       v1_reg;
    logic       disc_ok1_reg;
    logic       big_ok1_reg;
    logic [6:0] rem1_reg;

    logic       v2_reg;
    logic       disc_ok2_reg;
    logic       big_ok2_reg;
    logic [14:0] disc_x_reg;

    logic [NUM_VERTS-1:0] flip;
    logic [NUM_BLOBS-1:0] blob_in;
    logic        star_in;
    logic [27:0] dq;
    logic [7:0]  alpha_d;
    psr_cov_t    cov_reg;
    psr_cov_t    cov_next;

    assign px   = {2'b00, col, 1'b1, 7'd0};
    assign py   = {2'b00, row, 1'b1, 7'd0};
    assign cpos = $signed({1'b0, 9'(9'(col) * 9'd10 + 9'd5)});
    assign rpos = $signed({1'b0, 9'(9'(row) * 9'd10 + 9'd5)});
    assign dxd  = $signed({1'b0, col, 1'b0}) - 7'sd9;
    assign dyd  = $signed({1'b0, row, 1'b0}) - 7'sd9;
    assign sqx  = dxd * dxd;
    assign sqy  = dyd * dyd;
    assign dsq  = 14'(sqx) + 14'(sqy);
    assign rem  = DISC_RAD_SQ - dsq;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            disc_ok1_reg <= (col < DISC_SIZE) && (row < DISC_SIZE) && (dsq <= DISC_RAD_SQ);
            big_ok1_reg  <= (col < SPRITE_SIZE) && (row < SPRITE_SIZE);
            rem1_reg     <= rem[6:0];
            disc_ok2_reg <= disc_ok1_reg;
            big_ok2_reg  <= big_ok1_reg;
            disc_x_reg   <= 15'(cfg.opacity) * 15'(rem1_reg);
        end
    end

    // Even-odd crossing test, one lane per star edge.
    for (genvar k = 0; k < NUM_VERTS; k++)
    begin : g_edge
        localparam int P = (k == 0) ? NUM_VERTS - 1 : k - 1;
        localparam logic signed [14:0] DYK = STAR_Y[P] - STAR_Y[k];
        localparam logic signed [14:0] DXK = STAR_X[P] - STAR_X[k];

        logic signed [14:0] ex_reg;
        logic signed [14:0] ey_reg;
        logic               cross1_reg;
        logic signed [29:0] lhs_reg;
        logic signed [29:0] rhs_reg;
        logic               cross2_reg;
        logic               left;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ex_reg     <= px - STAR_X[k];
                ey_reg     <= py - STAR_Y[k];
                cross1_reg <= (STAR_Y[k] > py) ^ (STAR_Y[P] > py);
                lhs_reg    <= ex_reg * DYK;
                rhs_reg    <= DXK * ey_reg;
                cross2_reg <= cross1_reg;
            end
        end

        assign left    = (DYK > 15'sd0) ? (lhs_reg < rhs_reg) : (lhs_reg > rhs_reg);
        assign flip[k] = cross2_reg && left;
    end

    assign star_in = ^flip;

    // Ellipse test scaled down by the common factors of the offsets and radii.
    for (genvar k = 0; k < NUM_BLOBS; k++)
    begin : g_blob
        localparam logic signed [9:0] CXK = 10'(BLOB_CX3[k]);
        localparam logic signed [9:0] CYK = 10'(BLOB_CY3[k]);
        localparam logic signed [6:0] RXK = 7'(BLOB_RX[k]);
        localparam logic signed [6:0] RYK = 7'(BLOB_RY[k]);
        localparam logic [28:0] LIM =
            29'(9 * BLOB_RX[k] * BLOB_RX[k] * BLOB_RY[k] * BLOB_RY[k]);

        logic signed [15:0] au_reg;
        logic signed [15:0] bv_reg;
        logic signed [31:0] usq_full;
        logic signed [31:0] vsq_full;
        logic [27:0]        usq_reg;
        logic [27:0]        vsq_reg;
        logic [28:0]        sum;

        assign usq_full = au_reg * au_reg;
        assign vsq_full = bv_reg * bv_reg;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                au_reg  <= (cpos - CXK) * RYK;
                bv_reg  <= (rpos - CYK) * RXK;
                usq_reg <= usq_full[27:0];
                vsq_reg <= vsq_full[27:0];
            end
        end

        assign sum        = {1'b0, usq_reg} + {1'b0, vsq_reg};
        assign blob_in[k] = (sum <= LIM);
    end

    assign dq      = 28'(disc_x_reg) * 28'(RECIP_100);
    assign alpha_d = dq[SHIFT_100 +: 8];

    always_comb
    begin
        cov_next.valid = v2_reg;
        case (cfg.shape)
            SHAPE_STAR:
            begin
                cov_next.hit   = big_ok2_reg && star_in;
                cov_next.alpha = cfg.opacity;
            end
            SHAPE_BLOB:
            begin
                cov_next.hit   = big_ok2_reg && (|blob_in);
                cov_next.alpha = cfg.opacity;
            end
            default:
            begin
                cov_next.hit   = disc_ok2_reg;
                cov_next.alpha = alpha_d;
            end
        endcase
        if (!cov_next.hit)
        begin
            cov_next.alpha = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cov_reg <= '0;
        end
        else if (en)
        begin
            cov_reg <= cov_next;
        end
    end

    assign cov = cov_reg;

endmodule

// File: design/psr_shade.sv
`timescale 1ns / 1ps

module psr_shade
    import psr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  psr_cov_t    cov,
    input  psr_cfg_t    cfg,
    output logic        res_valid,
    output logic [31:0] argb_pixel,
    output logic        covered
);

    logic        v4_reg;
    logic        hit4_reg;
    logic [7:0]  a4_reg;
    logic [15:0] pr_reg;
    logic [15:0] pg_reg;
    logic [15:0] pb_reg;
    logic [31:0] qr;
    logic [31:0] qg;
    logic [31:0] qb;
    logic        valid_reg;
    logic        covered_reg;
    logic [31:0] argb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg    <= 1'b0;
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v4_reg    <= cov.valid;
            valid_reg <= v4_reg;
        end
    end

    assign qr = 32'(pr_reg) * 32'(RECIP_255);
    assign qg = 32'(pg_reg) * 32'(RECIP_255);
    assign qb = 32'(pb_reg) * 32'(RECIP_255);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit4_reg    <= cov.hit;
            a4_reg      <= cov.alpha;
            pr_reg      <= 16'(cfg.red) * 16'(cov.alpha);
            pg_reg      <= 16'(cfg.green) * 16'(cov.alpha);
            pb_reg      <= 16'(cfg.blue) * 16'(cov.alpha);
            covered_reg <= hit4_reg;
            argb_reg    <= {a4_reg, qr[SHIFT_255 +: 8], qg[SHIFT_255 +: 8],
                            qb[SHIFT_255 +: 8]};
        end
    end

    assign res_valid  = valid_reg;
    assign argb_pixel = argb_reg;
    assign covered    = covered_reg;

endmodule

// File: design/psr_checker.sv
`timescale 1ns / 1ps

module psr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        pix_valid,
    input logic        pix_stall,
    input logic        res_valid,
    input logic        res_stall,
    input logic [31:0] argb_pixel,
    input logic        covered
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(argb_pixel) && $stable(covered))
        else $error("Stalled output beat changed.");

    a_blank: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !covered |-> argb_pixel == 32'd0)
        else $error("Uncovered pixel is not blank.");

    a_premul: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && covered |-> (argb_pixel[23:16] <= argb_pixel[31:24])
            && (argb_pixel[15:8] <= argb_pixel[31:24])
            && (argb_pixel[7:0] <= argb_pixel[31:24]))
        else $error("Color channel exceeds alpha.");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid |-> pix_stall == (res_valid && res_stall))
        else $error("Input stall does not follow the output stall.");

endmodule

bind procedural_sprite_rasterizer psr_checker u_psr_checker (.*);
